[hw/rtl/acrms_pkg.sv]
package acrms_pkg;

   localparam int SAMPLE_W = 16;
   localparam int FRAC_W   = 4;
   localparam int OFS_W    = SAMPLE_W + FRAC_W;
   localparam int RMS_W    = 17 + FRAC_W;
   localparam int CUR_W    = 30;
   localparam int LEN_W    = 13;
   localparam int COEF_W   = 20;

   localparam logic [1:0] REG_WINDOW    = 2'd0;
   localparam logic [1:0] REG_CALIB     = 2'd1;
   localparam logic [1:0] REG_SLOPE     = 2'd2;
   localparam logic [1:0] REG_INTERCEPT = 2'd3;

   localparam logic KIND_MEASURE = 1'b0;
   localparam logic KIND_CALIB   = 1'b1;

   typedef struct packed {
      logic                       kind;
      logic [63:0]                sum;
      logic [16:0]                count;
      logic signed [SAMPLE_W-1:0] low;
      logic signed [SAMPLE_W-1:0] high;
   } job_type;

endpackage

[hw/rtl/acrms_front.sv]
module acrms_front #(
   parameter int CNT_W = 13
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_action,
   input  logic signed [acrms_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [CNT_W-1:0]                    win_len,
   input  logic [CNT_W-1:0]                    cal_len,
   input  logic signed [acrms_pkg::OFS_W-1:0]  offset,
   input  logic                                cal_busy,
   output logic                                job_valid,
   input  logic                                job_ready,
   output acrms_pkg::job_type                  job
);
   import acrms_pkg::*;

   logic [CNT_W-1:0] mcnt_ff, mcnt_in, ccnt_ff, ccnt_in;
   logic [63:0] ssum_ff, ssum_in;
   logic signed [39:0] csum_ff, csum_in;
   logic signed [SAMPLE_W-1:0] low_ff, low_in, high_ff, high_in;
   logic jv_ff, jv_in;
   job_type job_ff, job_in;
   logic take, done;
   logic signed [OFS_W+1:0] ac;
   logic [OFS_W:0] mag;
   logic [CNT_W-1:0] mnext, cnext;

   // hold samples while the job slot is full or a new offset is still being computed
   assign req_ready = (!jv_ff || (job_ready && job_ff.kind != KIND_CALIB)) && !cal_busy;
   assign take = req_valid && req_ready;
   assign ac = $signed({{2{req_sample[SAMPLE_W-1]}}, req_sample, {FRAC_W{1'b0}}})
             - $signed({{2{offset[OFS_W-1]}}, offset});
   assign mag = ac[OFS_W+1] ? (OFS_W+1)'(0) - ac[OFS_W:0] : ac[OFS_W:0];
   assign mnext = mcnt_ff + 1'b1;
   assign cnext = ccnt_ff + 1'b1;

   always_comb begin
      mcnt_in = mcnt_ff; ccnt_in = ccnt_ff; ssum_in = ssum_ff; csum_in = csum_ff;
      low_in = low_ff; high_in = high_ff;
      jv_in = jv_ff && !job_ready; job_in = job_ff; done = 1'b0;
      if (take) begin
         if (req_action) begin
            csum_in = csum_ff + 40'(req_sample);
            ccnt_in = cnext;
            done = cnext >= cal_len;
            if (done) begin
               job_in.kind = KIND_CALIB;
               job_in.sum = 64'(csum_in);
               job_in.count = 17'(cnext);
               job_in.low = '0; job_in.high = '0;
               csum_in = '0; ccnt_in = '0;
            end
         end else begin
            ssum_in = ssum_ff + 64'(mag * mag);
            if (req_sample < low_ff) low_in = req_sample;
            if (req_sample > high_ff) high_in = req_sample;
            mcnt_in = mnext;
            done = mnext >= win_len;
            if (done) begin
               job_in.kind = KIND_MEASURE;
               job_in.sum = ssum_in;
               job_in.count = 17'(mnext);
               job_in.low = low_in; job_in.high = high_in;
               ssum_in = '0; mcnt_in = '0;
               low_in = 16'sh7fff; high_in = -16'sh8000;
            end
         end
         if (done) jv_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (reset) begin
         mcnt_ff <= '0; ccnt_ff <= '0; ssum_ff <= '0; csum_ff <= '0;
         low_ff <= 16'sh7fff; high_ff <= -16'sh8000; jv_ff <= 1'b0;
      end else begin
         mcnt_ff <= mcnt_in; ccnt_ff <= ccnt_in; ssum_ff <= ssum_in; csum_ff <= csum_in;
         low_ff <= low_in; high_ff <= high_in; jv_ff <= jv_in;
      end
   end

   assign job_valid = jv_ff;
   assign job = job_ff;
endmodule

[hw/rtl/acrms_back.sv]
module acrms_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 job_valid,
   output logic                                 job_ready,
   input  acrms_pkg::job_type                   job,
   input  logic [acrms_pkg::COEF_W-1:0]         slope,
   input  logic [acrms_pkg::COEF_W-1:0]         intercept,
   output logic signed [acrms_pkg::OFS_W-1:0]   offset,
   output logic                                 cal_busy,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_kind,
   output logic [acrms_pkg::RMS_W-1:0]          rsp_rms_counts_q4,
   output logic signed [acrms_pkg::CUR_W-1:0]   rsp_current_ua,
   output logic signed [acrms_pkg::SAMPLE_W-1:0] rsp_min_sample,
   output logic signed [acrms_pkg::SAMPLE_W-1:0] rsp_max_sample,
   output logic [acrms_pkg::SAMPLE_W-1:0]       rsp_peak_to_peak,
   output logic signed [acrms_pkg::OFS_W-1:0]   rsp_offset_q4
);
   import acrms_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001, S_DIV = 6'b000010, S_SQRT = 6'b000100,
      S_MUL = 6'b001000, S_FIN = 6'b010000, S_OUT = 6'b100000
   } state_type;

   state_type st_ff, st_in;
   job_type jb_ff;
   logic [63:0] q_ff, q_in;
   logic [17:0] r_ff, r_in;
   logic [6:0] i_ff, i_in;
   logic neg_ff;
   logic [63:0] rem_ff, res_ff, bit_ff;
   logic [41:0] prod_ff;
   logic signed [OFS_W-1:0] ofs_ff;
   logic [18:0] rtry;
   logic [63:0] num;
   logic [64:0] sqt;
   logic [63:0] sres;

   assign job_ready = st_ff == S_IDLE;
   // new offset not yet in force
   assign cal_busy = (st_ff != S_IDLE) && (st_ff != S_OUT) && (jb_ff.kind == KIND_CALIB);
   // numerator: measure sum, or |2*16*csum|+n for rounded calibration
   always_comb begin
      if (job.kind == KIND_CALIB) begin
         num = job.sum[63] ? (64'd0 - job.sum) : job.sum;
         num = (num << (FRAC_W + 1)) + 64'(job.count);
      end else num = job.sum;
   end

   assign rtry = {r_ff, q_ff[63]} - {1'b0, (jb_ff.kind == KIND_CALIB) ?
                 {jb_ff.count, 1'b0} : {1'b0, jb_ff.count}};
   assign sqt = {1'b0, rem_ff} - {1'b0, res_ff + bit_ff};
   assign sres = q_ff;

   always_comb begin
      st_in = st_ff; q_in = q_ff; r_in = r_ff; i_in = i_ff;
      unique case (st_ff)
         S_IDLE: if (job_valid) begin
            st_in = S_DIV; q_in = num; r_in = '0; i_in = 7'd64;
         end
         S_DIV: begin
            if (!rtry[18]) begin
               r_in = rtry[17:0]; q_in = {q_ff[62:0], 1'b1};
            end else begin
               r_in = {r_ff[16:0], q_ff[63]}; q_in = {q_ff[62:0], 1'b0};
            end
            i_in = i_ff - 1'b1;
            if (i_ff == 7'd1) st_in = (jb_ff.kind == KIND_CALIB) ? S_FIN : S_SQRT;
         end
         S_SQRT: begin
            i_in = i_ff - 1'b1;
            if (i_ff == 7'd1) st_in = S_MUL;
         end
         S_MUL: st_in = S_FIN;
         S_FIN: st_in = S_OUT;
         S_OUT: if (rsp_ready) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in;
      if (st_ff == S_IDLE) begin
         jb_ff <= job; neg_ff <= job.sum[63];
      end
      if (st_ff == S_DIV && i_ff == 7'd1) begin
         rem_ff <= q_in; res_ff <= '0; bit_ff <= 64'h4000_0000_0000_0000;
      end
      if (st_ff == S_SQRT) begin
         if (!sqt[64]) begin
            rem_ff <= sqt[63:0]; res_ff <= (res_ff >> 1) + bit_ff;
         end else res_ff <= res_ff >> 1;
         bit_ff <= bit_ff >> 2;
      end
      if (st_ff == S_MUL) prod_ff <= res_ff[RMS_W-1:0] * slope;
      if (st_ff == S_FIN) begin
         if (jb_ff.kind == KIND_CALIB) begin
            ofs_ff <= neg_ff ? OFS_W'(0) - sres[OFS_W-1:0] : sres[OFS_W-1:0];
            rsp_rms_counts_q4 <= '0; rsp_current_ua <= '0;
            rsp_min_sample <= '0; rsp_max_sample <= '0; rsp_peak_to_peak <= '0;
         end else begin
            rsp_rms_counts_q4 <= res_ff[RMS_W-1:0];
            rsp_current_ua <= CUR_W'((prod_ff + 42'd2048) >> 12) - CUR_W'(intercept);
            rsp_min_sample <= jb_ff.low; rsp_max_sample <= jb_ff.high;
            rsp_peak_to_peak <= jb_ff.high - jb_ff.low;
         end
         rsp_kind <= jb_ff.kind;
      end
      if (st_ff == S_DIV && i_ff == 7'd1) i_ff <= 7'd32; else i_ff <= i_in;
      if (reset) begin
         st_ff <= S_IDLE; ofs_ff <= '0;
      end else st_ff <= st_in;
   end

   assign offset = ofs_ff;
   assign rsp_offset_q4 = ofs_ff;
   assign rsp_valid = st_ff == S_OUT;
endmodule

[hw/rtl/ac_rms_current_meter_unit.sv]
// channel | direction | transaction
// req     | in        | action, sample
// rsp     | out       | window or calibration result
// csr     | in/out    | register write and read
// a sample is taken each cycle unless the job slot is full or an offset is being computed
// window end: divide, square root, multiply, finish
// calibration end: divide and finish, samples wait for the new offset
// the front keeps accumulating while the back computes a window; one job is buffered
// synchronous active-high reset clears counts, sums and offset
module ac_rms_current_meter_unit #(
   parameter int MAX_WINDOW = 4096
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_action,
   input  logic signed [15:0] req_sample,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_kind,
   output logic [20:0] rsp_rms_counts_q4,
   output logic signed [29:0] rsp_current_ua,
   output logic signed [15:0] rsp_min_sample,
   output logic signed [15:0] rsp_max_sample,
   output logic [15:0] rsp_peak_to_peak,
   output logic signed [19:0] rsp_offset_q4,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [3:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   import acrms_pkg::*;
   localparam int CNT_W = $clog2(MAX_WINDOW) + 1;

   logic [LEN_W-1:0] win_ff, cal_ff;
   logic [COEF_W-1:0] slope_ff, icpt_ff;
   logic [CNT_W-1:0] win_eff, cal_eff;
   logic signed [OFS_W-1:0] offset;
   logic cal_busy;
   logic job_valid, job_ready;
   job_type job;
   logic [1:0] ridx;

   assign pready = 1'b1;
   assign ridx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= 13'd2000; cal_ff <= 13'd500; slope_ff <= 20'd458446; icpt_ff <= 20'd8807;
      end else if (psel && penable && pwrite) begin
         unique case (ridx)
            REG_WINDOW:    win_ff <= pwdata[LEN_W-1:0];
            REG_CALIB:     cal_ff <= pwdata[LEN_W-1:0];
            REG_SLOPE:     slope_ff <= pwdata[COEF_W-1:0];
            REG_INTERCEPT: icpt_ff <= pwdata[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (ridx)
         REG_WINDOW:    prdata = 32'(win_ff);
         REG_CALIB:     prdata = 32'(cal_ff);
         REG_SLOPE:     prdata = 32'(slope_ff);
         REG_INTERCEPT: prdata = 32'(icpt_ff);
         default:       prdata = '0;
      endcase
   end

   always_comb begin
      if (win_ff == '0) win_eff = CNT_W'(1);
      else if (32'(win_ff) > MAX_WINDOW) win_eff = CNT_W'(MAX_WINDOW);
      else win_eff = CNT_W'(win_ff);
      if (cal_ff == '0) cal_eff = CNT_W'(1);
      else if (32'(cal_ff) > MAX_WINDOW) cal_eff = CNT_W'(MAX_WINDOW);
      else cal_eff = CNT_W'(cal_ff);
   end

   acrms_front #(.CNT_W(CNT_W)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_action, .req_sample,
      .win_len(win_eff), .cal_len(cal_eff), .offset, .cal_busy,
      .job_valid, .job_ready, .job
   );

   acrms_back u_back (
      .clock, .reset, .job_valid, .job_ready, .job,
      .slope(slope_ff), .intercept(icpt_ff), .offset, .cal_busy,
      .rsp_valid, .rsp_ready, .rsp_kind, .rsp_rms_counts_q4, .rsp_current_ua,
      .rsp_min_sample, .rsp_max_sample, .rsp_peak_to_peak, .rsp_offset_q4
   );
endmodule

[hw/rtl/acrms_checker.sv]
module acrms_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_kind,
   input logic [20:0] rsp_rms_counts_q4,
   input logic [15:0] rsp_min_sample,
   input logic [15:0] rsp_max_sample,
   input logic [15:0] rsp_peak_to_peak,
   input logic pready
);
   a_pready: assert property (@(posedge clock) pready) else $error("pready low");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rms_counts_q4))
      else $error("rsp dropped");
   a_p2p: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kind |->
      rsp_peak_to_peak == 16'(rsp_max_sample - rsp_min_sample))
      else $error("peak to peak mismatch");
   a_cal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> rsp_rms_counts_q4 == '0)
      else $error("calibration rms nonzero");
endmodule

bind ac_rms_current_meter_unit acrms_checker u_checker (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_kind, .rsp_rms_counts_q4,
   .rsp_min_sample, .rsp_max_sample, .rsp_peak_to_peak, .pready
);
